/* sv/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// Block pool allocator package
// Command, status and register codes, FSM states and the remainder chain
// data type shared by the allocator modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int DEF_MAX_BLOCKS    = 256;
   localparam int DEF_BLOCKS_IN_USE = 8;
   localparam int DEF_BLOCK_LOG2    = 5;
   localparam int MIN_BLOCK_LOG2    = 3;
   localparam int MAX_BLOCK_LOG2    = 12;

   localparam int WORD_W      = 32;
   localparam int REM_W       = 12;   // holds an index for pools of up to 4096 blocks
   localparam int CELL_BITS   = 4;    // quotient bits consumed per cell
   localparam int N_CELLS     = WORD_W / CELL_BITS;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_REINIT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NULL_FREE = 2'd2
   } status_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_LOG2  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_COUNT = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ALLOC_LINK,
      S_FREE_WAIT
   } state_type;

   // Transaction moving down the remainder chain
   typedef struct packed {
      logic              valid;
      logic [REM_W-1:0]  rem;
      logic [WORD_W-1:0] word;
   } chain_data_type;

   // Clamp the block size exponent to its legal range
   function automatic logic [3:0] eff_log2(input logic [3:0] raw);
      logic [3:0] s;
      s = raw;
      if (s < 4'(MIN_BLOCK_LOG2)) s = 4'(MIN_BLOCK_LOG2);
      if (s > 4'(MAX_BLOCK_LOG2)) s = 4'(MAX_BLOCK_LOG2);
      return s;
   endfunction

endpackage

/* sv/fixed_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// LIFO free list over a pool of equal power-of-two blocks: allocate, free
// and reinitialise commands, one response strobe per transaction.
// ----------------------------------------------------------------------------
// Alloc of an untouched block, reinit, null free: response in the cycle
//   after acceptance, next transaction accepted the following cycle.
// Alloc of a freed block: busy until the response, which follows the link memory read.
// Free: busy until the response, which waits for the remainder chain.
// Reset: control and configuration return to defaults; the link memory is not
//   cleared and needs no clearing pass. The receiver cannot stall responses.
module fixed_block_pool_allocator
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_cmd,
   input  logic [31:0]            req_release_address,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_block_address,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int HEAD_W = $clog2(MAX_BLOCKS+1);
   localparam logic [HEAD_W-1:0] NULL_MARK   = HEAD_W'(MAX_BLOCKS);
   localparam int                RESET_COUNT =
      (DEF_BLOCKS_IN_USE > MAX_BLOCKS) ? MAX_BLOCKS : DEF_BLOCKS_IN_USE;

   // configuration
   logic [31:0] pool_base_ff;
   logic [3:0]  block_log2_ff;
   logic [8:0]  block_count_ff;

   state_type   state_ff, state_in;
   logic [HEAD_W-1:0] freed_head_ff, freed_head_in;
   logic [HEAD_W-1:0] untouched_ff, untouched_in;
   logic [31:0]       pending_addr_ff, pending_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [31:0]       rsp_addr_ff, rsp_addr_in;
   chain_data_type    chain_in_ff, chain_in_in;
   chain_data_type    chain_out;

   logic              accept;
   logic              head_valid;
   logic [3:0]        shift_amt;
   logic [HEAD_W-1:0] untouched_dec;
   logic [HEAD_W-1:0] count_clamped;
   logic [31:0]       head_addr;
   logic [31:0]       untouched_addr;
   logic [31:0]       release_block;

   logic              mem_re, mem_we;
   logic [HEAD_W-1:0] mem_rdata;

   assign accept        = start && !busy;
   assign busy          = (state_ff != S_IDLE);
   assign head_valid    = (freed_head_ff != NULL_MARK);
   assign shift_amt     = eff_log2(block_log2_ff);
   assign untouched_dec = untouched_ff - HEAD_W'(1);
   assign count_clamped = (32'(block_count_ff) > 32'(MAX_BLOCKS)) ?
                          NULL_MARK : HEAD_W'(block_count_ff);
   assign head_addr      = pool_base_ff + (32'(freed_head_ff) << shift_amt);
   assign untouched_addr = pool_base_ff + (32'(untouched_dec) << shift_amt);
   assign release_block  = (req_release_address - pool_base_ff) >> shift_amt;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= '0;
         block_log2_ff  <= 4'(DEF_BLOCK_LOG2);
         block_count_ff <= 9'(DEF_BLOCKS_IN_USE);
      end else if (csr_we) begin
         case (csr_index)
            CSR_POOL_BASE:   pool_base_ff   <= csr_wdata;
            CSR_BLOCK_LOG2:  block_log2_ff  <= csr_wdata[3:0];
            CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_ALLOC && head_valid) begin
                  state_in = S_ALLOC_LINK;
               end else if (req_cmd == CMD_FREE && req_release_address != '0) begin
                  state_in = S_FREE_WAIT;
               end
            end
         end
         S_ALLOC_LINK: state_in = S_IDLE;
         S_FREE_WAIT: begin
            if (chain_out.valid) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // --------------------------------------------------------------- outputs
   always_comb begin
      freed_head_in   = freed_head_ff;
      untouched_in    = untouched_ff;
      pending_addr_in = pending_addr_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = STAT_DONE;
      rsp_addr_in     = '0;
      mem_re          = 1'b0;
      mem_we          = 1'b0;
      chain_in_in     = '{valid: 1'b0, rem: '0, word: release_block};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_ALLOC: begin
                     if (head_valid) begin
                        // pop: fetch the link below the head
                        mem_re          = 1'b1;
                        pending_addr_in = head_addr;
                     end else if (untouched_ff != '0) begin
                        untouched_in = untouched_dec;
                        rsp_valid_in = 1'b1;
                        rsp_addr_in  = untouched_addr;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end
                  end
                  CMD_FREE: begin
                     if (req_release_address == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_NULL_FREE;
                     end else begin
                        chain_in_in.valid = 1'b1;
                     end
                  end
                  CMD_REINIT: begin
                     freed_head_in = NULL_MARK;
                     untouched_in  = count_clamped;
                     rsp_valid_in  = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_ALLOC_LINK: begin
            freed_head_in = mem_rdata;
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = pending_addr_ff;
         end
         S_FREE_WAIT: begin
            if (chain_out.valid) begin
               // push: link the freed block above the old head
               mem_we        = 1'b1;
               freed_head_in = HEAD_W'(chain_out.rem[IDX_W-1:0]);
               rsp_valid_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         freed_head_ff     <= NULL_MARK;
         untouched_ff      <= HEAD_W'(RESET_COUNT);
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         freed_head_ff     <= freed_head_in;
         untouched_ff      <= untouched_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_addr_ff   <= pending_addr_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_addr_ff       <= rsp_addr_in;
      chain_in_ff.valid <= reset ? 1'b0 : chain_in_in.valid;
      chain_in_ff.rem   <= chain_in_in.rem;
      chain_in_ff.word  <= chain_in_in.word;
   end

   fbpa_rem_chain #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .chain_in (chain_in_ff),
      .chain_out(chain_out)
   );

   fbpa_link_ram #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_link_ram (
      .clock     (clock),
      .write_en  (mem_we),
      .write_addr(chain_out.rem[IDX_W-1:0]),
      .write_data(freed_head_ff),
      .read_en   (mem_re),
      .read_addr (freed_head_ff[IDX_W-1:0]),
      .read_data (mem_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;

   // ------------------------------------------------------------ assertions
   a_rsp_follows_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("response strobe without a transaction in progress");

   a_free_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_FREE && req_release_address != '0) |=> busy)
      else $error("non-null free did not enter the chain wait");

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      freed_head_ff <= NULL_MARK)
      else $error("free list head beyond the null marker");

   a_chain_only_in_free: assert property (@(posedge clock) disable iff (reset)
      chain_out.valid |-> state_ff == S_FREE_WAIT)
      else $error("remainder chain output outside a free transaction");

endmodule

/* sv/fbpa_rem_cell.sv */
// ----------------------------------------------------------------------------
// Remainder cell
// Consumes the top quotient bits of the word, folding them into a running
// remainder modulo the pool size, and hands the result to the next cell.
// ----------------------------------------------------------------------------
module fbpa_rem_cell
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
   input  logic           clock,
   input  logic           reset,
   input  chain_data_type d_in,
   output chain_data_type d_out
);

   localparam logic [REM_W:0] MODULUS = (REM_W+1)'(MAX_BLOCKS);

   logic [REM_W:0]    r;
   logic              valid_ff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [WORD_W-1:0] word_ff, word_in;

   always_comb begin
      r = {1'b0, d_in.rem};
      for (int k = 0; k < CELL_BITS; k++) begin
         r = {r[REM_W-1:0], d_in.word[WORD_W-1-k]};
         if (r >= MODULUS) r = r - MODULUS;
      end
      rem_in  = r[REM_W-1:0];
      word_in = d_in.word << CELL_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= d_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      word_ff <= word_in;
   end

   assign d_out = '{valid: valid_ff, rem: rem_ff, word: word_ff};

endmodule

/* sv/fbpa_rem_chain.sv */
// ----------------------------------------------------------------------------
// Remainder chain
// Row of registered remainder cells reducing a block number modulo the pool
// size, four bits per cell.
// ----------------------------------------------------------------------------
module fbpa_rem_chain
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
   input  logic           clock,
   input  logic           reset,
   input  chain_data_type chain_in,
   output chain_data_type chain_out
);

   chain_data_type link [N_CELLS+1];

   assign link[0] = chain_in;

   for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
      fbpa_rem_cell #(
         .MAX_BLOCKS(MAX_BLOCKS)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .d_in (link[c]),
         .d_out(link[c+1])
      );
   end

   assign chain_out = link[N_CELLS];

endmodule

/* sv/fbpa_link_ram.sv */
// ----------------------------------------------------------------------------
// Free list link memory
// One entry per block holding the next freed block below it; registered
// read, separate read and write ports.
// ----------------------------------------------------------------------------
module fbpa_link_ram
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
   input  logic                              clock,
   input  logic                              write_en,
   input  logic [$clog2(MAX_BLOCKS)-1:0]     write_addr,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]   write_data,
   input  logic                              read_en,
   input  logic [$clog2(MAX_BLOCKS)-1:0]     read_addr,
   output logic [$clog2(MAX_BLOCKS+1)-1:0]   read_data
);

   localparam int DATA_W = $clog2(MAX_BLOCKS+1);

   logic [DATA_W-1:0] mem [MAX_BLOCKS];
   logic [DATA_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule
